// File: design/pr32_pkg.sv
// Package for the 3:2 polyphase resampler: coefficient table, widths and phase codes.
// No dependencies.
`default_nettype none
package pr32_pkg;
    localparam int SAMPLE_W = 16;
    localparam int COEF_TAPS = 16;
    localparam int FRAC_BITS = 15;
    localparam int ACC_W = 40;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    localparam logic [1:0] PH_SKIP = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_A = 2'd2;

    // Coefficient for phase p (0 = A, 1 = B) at delay d; zero beyond the table.
    function automatic sample_t coef_at(input logic p, input logic [6:0] d);
        sample_t rom [0:31];
        logic [4:0] idx;
        rom = '{16'sd19, 16'sd0, -16'sd325, 16'sd765, 16'sd0, -16'sd3305, 16'sd8088,
                16'sd21580, 16'sd8923, -16'sd4044, 16'sd0, 16'sd1204, -16'sd612, 16'sd0,
                16'sd93, -16'sd16, 16'sd20, -16'sd118, 16'sd0, 16'sd874, -16'sd1927,
                16'sd0, 16'sd16176, 16'sd17847, 16'sd0, -16'sd3235, 16'sd1888, 16'sd0,
                -16'sd556, 16'sd250, 16'sd0, -16'sd15};
        idx = {p, 4'd15 - d[3:0]};
        if (d >= 7'd16) begin
            return '0;
        end
        return rom[idx];
    endfunction
endpackage
`default_nettype wire

// File: design/pr32_mac.sv
// Bit-serial MAC into acc: one coefficient bit per cycle while step is high.
// Depends on pr32_pkg.
`default_nettype none
module pr32_mac import pr32_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    clear,
    input  wire logic    load,
    input  wire sample_t samp,
    input  wire sample_t coef,
    input  wire logic    step,
    output acc_t         acc
);
    acc_t acc_reg, acc_next;
    acc_t mcand_reg, mcand_next;
    logic [SAMPLE_W-1:0] mplier_reg, mplier_next;
    logic [3:0] bit_reg, bit_next;

    // Shift-add: last multiplier bit carries negative weight.
    always_comb begin
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        bit_next = bit_reg;
        if (clear) begin
            acc_next = '0;
        end
        if (load) begin
            mcand_next = ACC_W'(samp);
            mplier_next = coef;
            bit_next = '0;
        end else if (step) begin
            if (mplier_reg[0]) begin
                acc_next = (bit_reg == 4'd15) ? acc_reg - mcand_reg : acc_reg + mcand_reg;
            end
            mcand_next = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            bit_next = bit_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
        bit_reg <= bit_next;
    end

    assign acc = acc_reg;
endmodule
`default_nettype wire

// File: design/polyphase_resampler_3to2.sv
// 3:2 polyphase FIR resampler top level: history ring, tap sequencer, output register.
// Depends on pr32_pkg and pr32_mac.
//
//  channel | ports               | payload
//  in      | s_axis_t*           | tdata[15:0] sample
//  out     | m_axis_t*           | tdata[15:0] out_sample
//
// An input that is due no result leaves the sequencer idle; else the sequencer takes
// each tap through a load state and one bit-serial multiply step per coefficient bit.
// Reset clears the ring valid bits, pointer and phase. A stalled output holds
// its register; the sequencer then waits in its last state until that register
// is free, and the next input is accepted only once the sequencer is idle.
`default_nettype none
module polyphase_resampler_3to2 import pr32_pkg::*; #(
    parameter int TAPS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [15:0] out_sample
);
    localparam int PW = $clog2(TAPS);
    localparam int CW = $clog2(TAPS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_MUL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    sample_t ring_mem [0:TAPS-1];
    logic [TAPS-1:0] vld_reg;
    logic [PW-1:0] wp_reg;
    logic [1:0] phase_reg;
    logic [1:0] state_reg;
    logic [CW-1:0] tap_reg;
    logic [3:0] cyc_reg;
    logic sel_b_reg;
    sample_t rd_reg;
    logic m_valid_reg;
    logic [15:0] m_data_reg;
    acc_t acc;
    logic [PW-1:0] wp_new;
    logic [PW-1:0] rd_idx;
    logic take;
    logic out_load;
    logic mac_clear, mac_load, mac_step;
    acc_t q;

    assign wp_new = (wp_reg == PW'(TAPS - 1)) ? '0 : wp_reg + 1'b1;
    assign rd_idx = (wp_reg >= PW'(tap_reg)) ? wp_reg - PW'(tap_reg)
                                             : PW'(TAPS) + wp_reg - PW'(tap_reg);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign take = s_axis_tvalid && s_axis_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);
    assign mac_clear = take;
    assign mac_load = (state_reg == ST_LOAD);
    assign mac_step = (state_reg == ST_MUL);

    // Ring write and registered read of the tap sample. The newest sample
    // bypasses the ring so that tap zero is ready at the first load.
    always_ff @(posedge aclk) begin
        if (take) begin
            ring_mem[wp_new] <= s_axis_tdata;
            rd_reg <= s_axis_tdata;
        end else begin
            rd_reg <= vld_reg[rd_idx] ? ring_mem[rd_idx] : '0;
        end
    end

    pr32_mac u_mac (
        .aclk  (aclk),
        .clear (mac_clear),
        .load  (mac_load),
        .samp  (rd_reg),
        .coef  (coef_at(sel_b_reg, 7'(tap_reg))),
        .step  (mac_step),
        .acc   (acc)
    );

    assign q = acc >>> FRAC_BITS;

    // Sequencer over taps and multiplier bits, with the input phase, ring pointer and output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            wp_reg <= '0;
            phase_reg <= PH_SKIP;
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
            tap_reg <= '0;
            cyc_reg <= '0;
            sel_b_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        wp_reg <= wp_new;
                        vld_reg[wp_new] <= 1'b1;
                        tap_reg <= '0;
                        if (phase_reg == PH_SKIP) begin
                            phase_reg <= PH_B;
                        end else begin
                            sel_b_reg <= (phase_reg == PH_B);
                            phase_reg <= (phase_reg == PH_B) ? PH_A : PH_SKIP;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    cyc_reg <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    cyc_reg <= cyc_reg + 4'd1;
                    // Move to the next tap early so its sample is read before the next load.
                    if (cyc_reg == 4'd0) begin
                        tap_reg <= tap_reg + 1'b1;
                    end
                    if (cyc_reg == 4'd15) begin
                        state_reg <= (tap_reg == CW'(TAPS)) ? ST_DONE : ST_LOAD;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Saturate the scaled sum into the output register.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (q > acc_t'(32767)) begin
                m_data_reg <= 16'h7FFF;
            end else if (q < -acc_t'(32768)) begin
                m_data_reg <= 16'h8000;
            end else begin
                m_data_reg <= q[15:0];
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = m_data_reg;
endmodule
`default_nettype wire

// File: tb/polyphase_resampler_3to2_tb.sv
// Testbench for the 3:2 polyphase resampler: drives sample transfers with bursts and gaps,
// predicts each filtered output and compares it with the block's output stream.
// Depends on pr32_pkg and the polyphase_resampler_3to2 design.
`timescale 1ns / 100ps
`default_nettype none
module polyphase_resampler_3to2_tb;
    import pr32_pkg::*;

    localparam int TAPS = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = TAPS * 17 + 20;

    // Coefficients, entry 16p+t weighting delay 15-t (p: 0 = phase A, 1 = phase B).
    localparam logic signed [15:0] FIR_COEF [0:31] = '{
        16'sd19, 16'sd0, -16'sd325, 16'sd765, 16'sd0, -16'sd3305, 16'sd8088, 16'sd21580,
        16'sd8923, -16'sd4044, 16'sd0, 16'sd1204, -16'sd612, 16'sd0, 16'sd93, -16'sd16,
        16'sd20, -16'sd118, 16'sd0, 16'sd874, -16'sd1927, 16'sd0, 16'sd16176, 16'sd17847,
        16'sd0, -16'sd3235, 16'sd1888, 16'sd0, -16'sd556, 16'sd250, 16'sd0, -16'sd15};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [15:0] sample
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [15:0] out_sample

    // Predictor state: history ring, newest-sample pointer and group phase.
    sample_t     hist_ring [0:TAPS-1];
    logic [3:0]  newest_ptr;
    logic [1:0]  group_ph;
    sample_t     expected_out [$];

    int unsigned error_count = 0;
    int unsigned checked_count = 0;
    int unsigned sample_count = 0;
    int unsigned cycle_count = 0;
    bit          rx_stall_mode = 1'b0;

    polyphase_resampler_3to2 #(.TAPS(TAPS)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 aclk = ~aclk;

    // Dot product over the ring for one phase, floor shift and saturation.
    function automatic sample_t fir_output(input logic ph_b);
        longint acc;
        longint q;
        int idx;
        acc = 0;
        for (int d = 0; d < TAPS; d++) begin
            idx = (int'(newest_ptr) + TAPS - d) % TAPS;
            if (d < 16) begin
                acc += longint'(hist_ring[idx]) * longint'(FIR_COEF[ph_b * 16 + 15 - d]);
            end
        end
        q = acc >>> FRAC_BITS;
        if (q > 32767) begin
            q = 32767;
        end
        if (q < -32768) begin
            q = -32768;
        end
        return sample_t'(q);
    endfunction

    // Advance the predictor by one accepted sample.
    task automatic predict_sample(input sample_t s);
        newest_ptr = newest_ptr + 4'd1;
        hist_ring[newest_ptr] = s;
        case (group_ph)
            PH_SKIP: begin
                group_ph = PH_B;
            end
            PH_B: begin
                expected_out.push_back(fir_output(1'b1));
                group_ph = PH_A;
            end
            default: begin
                expected_out.push_back(fir_output(1'b0));
                group_ph = PH_SKIP;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Send one sample; holds tvalid until the transfer completes. tvalid stays high
    // afterwards so that a following send can go back to back.
    task automatic send_sample(input sample_t s);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do @(posedge aclk); while (!s_axis_tready);
        predict_sample(s);
        sample_count++;
        @(negedge aclk);
    endtask

    // Drop tvalid and let the input idle for a number of cycles.
    task automatic idle_cycles(input int unsigned n);
        if (n != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    // Random gap after a send, on average after one send in four.
    task automatic maybe_gap();
        if ($urandom_range(0, 3) == 0) begin
            idle_cycles($urandom_range(1, 40));
        end
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (expected_out.size() != 0) @(negedge aclk);
    endtask

    task automatic test_extremes();
        sample_t edge_vals [0:5];
        edge_vals = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh5555, -16'sh5556};
        foreach (edge_vals[i]) begin
            send_sample(edge_vals[i]);
        end
        // Full-scale runs of both signs.
        repeat (9) send_sample(16'sh7FFF);
        repeat (9) send_sample(-16'sh8000);
        wait_drained();
    endtask

    // Fill the history with full-scale samples whose signs follow the phase A
    // coefficients, so that the phase A result saturates.
    task automatic send_matched(input bit negate);
        sample_t v;
        while (group_ph != PH_A) send_sample('0);
        for (int d = 15; d >= 0; d--) begin
            v = ((FIR_COEF[15 - d] < 0) != negate) ? -16'sh8000 : 16'sh7FFF;
            send_sample(v);
        end
    endtask

    task automatic test_saturation();
        send_matched(1'b0);
        send_matched(1'b1);
        wait_drained();
    endtask

    task automatic test_random_bursts(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst && sent < count; i++) begin
                case ($urandom_range(0, 3))
                    0: send_sample(sample_t'($urandom));
                    1: send_sample($urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000);
                    2: send_sample(sample_t'($urandom_range(0, 64)) - 16'sd32);
                    default: send_sample(sample_t'($urandom) >>> $urandom_range(0, 15));
                endcase
                sent++;
            end
            idle_cycles($urandom_range(0, 25));
        end
    endtask

    task automatic test_pause_until_empty();
        repeat (7) begin
            send_sample(sample_t'($urandom));
            maybe_gap();
        end
        wait_drained();
        repeat (5) send_sample(sample_t'($urandom));
    endtask

    // Receiver backpressure: alternate between a free-running and a stalling pattern.
    always @(negedge aclk) begin
        if (aresetn) begin
            if ($urandom_range(0, 99) == 0) begin
                rx_stall_mode <= ~rx_stall_mode;
            end
            if (rx_stall_mode) begin
                m_axis_tready <= ($urandom_range(0, 2) == 0);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Output checker and cycle limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            checked_count <= checked_count + 1;
            if (expected_out.size() == 0) begin
                report_mismatch($sformatf("unexpected output %0d", $signed(m_axis_tdata)));
            end else if ($signed(m_axis_tdata) != expected_out[0]) begin
                report_mismatch($sformatf("out_sample %0d, expected %0d",
                                $signed(m_axis_tdata), expected_out.pop_front()));
            end else begin
                void'(expected_out.pop_front());
            end
        end
    end

    initial begin
        for (int i = 0; i < TAPS; i++) begin
            hist_ring[i] = '0;
        end
        newest_ptr = '0;
        group_ph = PH_SKIP;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_extremes();
        test_saturation();
        test_pause_until_empty();
        test_random_bursts(1600);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (expected_out.size() != 0) begin
            report_mismatch($sformatf("%0d outputs never arrived", expected_out.size()));
        end
        $display("Sent %0d samples and checked %0d outputs, with saturation, bursts and stalls.",
                 sample_count, checked_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
